>>> hdl/rgch_pkg.sv
// Shared types and constants for the rg chromaticity histogram.
package rgch_pkg;

	// Histogram geometry.
	localparam int BINS_PER_AXIS = 16;
	localparam int BIN_W         = $clog2(BINS_PER_AXIS);
	localparam int CELLS         = BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int CELL_W        = $clog2(CELLS);

	// Pixel channels and the chromaticity bin division.
	localparam int CHAN_W     = 8;
	localparam int CHAN_MAX   = (1 << CHAN_W) - 1;
	localparam int SUM_W      = $clog2(3 * CHAN_MAX + 1);
	localparam int CHROMA_MUL = 2 * (BINS_PER_AXIS - 1);
	localparam int NUM_W      = $clog2(CHROMA_MUL * CHAN_MAX + 3 * CHAN_MAX + 1);
	localparam int DEN_W      = SUM_W + 1;
	localparam int DSH_W      = DEN_W + BIN_W - 1;
	localparam int CMP_W      = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int STEP_W     = (BIN_W > 1) ? $clog2(BIN_W) : 1;

	// Counts and the normalized fraction.
	localparam int MAX_PIXELS = 4194304;
	localparam int COUNT_W    = 23;
	localparam int FRAC_SHIFT = 16;
	localparam int FRAC_W     = FRAC_SHIFT + 1;
	localparam int FCNT_W     = $clog2(FRAC_W + 1);

	// Command queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Input item kinds.
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_READ,
		OP_CLEAR
	} op_t;

	// One queued command: the operation and the bin it targets.
	typedef struct packed {
		op_t              op;
		logic [BIN_W-1:0] row;
		logic [BIN_W-1:0] col;
	} cmd_t;

	typedef enum logic {
		F_IDLE,
		F_DIV
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_UPD,
		B_LOAD,
		B_DIV
	} back_state_t;

endpackage

>>> hdl/rg_chromaticity_histogram.sv
// Top level of the 16x16 rg chromaticity histogram.
//
//  Channel   Ports                                              Transfer
//  command   start, busy, kind, blue, green, red,               start high, busy low
//            read_red_bin, read_green_bin
//  result    done, bin_count, fraction, pixel_total, overflow   done high, one cycle
//
// In the front a pixel's bins take four chromaticity quotient bits, one per
// cycle; in the back it does a store read, then a write back. A bin read runs
// the seventeen-step fraction divider after the bin is loaded.
// A four-entry command queue lets the front take items while the back works.
// Reset empties the queue and marks every bin as zero at once; the user must
// take results when done is high, which the block itself does not enforce.
module rg_chromaticity_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic [rgch_pkg::CHAN_W-1:0]   blue,
	input  logic [rgch_pkg::CHAN_W-1:0]   green,
	input  logic [rgch_pkg::CHAN_W-1:0]   red,
	input  logic [rgch_pkg::BIN_W-1:0]    read_red_bin,
	input  logic [rgch_pkg::BIN_W-1:0]    read_green_bin,
	output logic                          done,
	output logic [rgch_pkg::COUNT_W-1:0]  bin_count,
	output logic [rgch_pkg::FRAC_W-1:0]   fraction,
	output logic [rgch_pkg::COUNT_W-1:0]  pixel_total,
	output logic                          overflow
);
	import rgch_pkg::*;

	logic  q_push, q_pop, q_full, q_empty;
	cmd_t  q_data, q_head;

	// Front: item transfer and bin computation.
	rgch_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.read_red_bin   (read_red_bin),
		.read_green_bin (read_green_bin),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_data)
	);

	// Command queue.
	rgch_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: count store and results.
	rgch_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.done        (done),
		.bin_count   (bin_count),
		.fraction    (fraction),
		.pixel_total (pixel_total),
		.overflow    (overflow)
	);

endmodule

>>> hdl/rgch_front.sv
// Front part: takes items, works out chromaticity bins and queues commands.
module rgch_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic [rgch_pkg::CHAN_W-1:0]  blue,
	input  logic [rgch_pkg::CHAN_W-1:0]  green,
	input  logic [rgch_pkg::CHAN_W-1:0]  red,
	input  logic [rgch_pkg::BIN_W-1:0]   read_red_bin,
	input  logic [rgch_pkg::BIN_W-1:0]   read_green_bin,
	input  logic                         q_full,
	output logic                         q_push,
	output rgch_pkg::cmd_t               q_data
);
	import rgch_pkg::*;

	front_state_t         state_q, state_d;
	logic [NUM_W-1:0]     rem_r_q, rem_g_q;
	logic [DSH_W-1:0]     dsh_q;
	logic [BIN_W-1:0]     qr_q, qg_q;
	logic [STEP_W-1:0]    step_q;

	logic                 accept;
	logic [SUM_W-1:0]     sum, sum1;
	logic [DEN_W-1:0]     den;
	logic                 ge_r, ge_g;
	logic [NUM_W-1:0]     rem_r_nx, rem_g_nx;
	logic [BIN_W-1:0]     qr_nx, qg_nx;

	assign busy   = (state_q != F_IDLE) || q_full;
	assign accept = start && !busy;

	// Channel sum, with a black pixel taken as a sum of one.
	always_comb begin
		sum  = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
		sum1 = (sum == '0) ? SUM_W'(1) : sum;
		den  = {sum1, 1'b0};
	end

	// One restoring quotient bit per cycle for both the red and green bins.
	always_comb begin
		ge_r     = CMP_W'(rem_r_q) >= CMP_W'(dsh_q);
		ge_g     = CMP_W'(rem_g_q) >= CMP_W'(dsh_q);
		rem_r_nx = ge_r ? NUM_W'(CMP_W'(rem_r_q) - CMP_W'(dsh_q)) : rem_r_q;
		rem_g_nx = ge_g ? NUM_W'(CMP_W'(rem_g_q) - CMP_W'(dsh_q)) : rem_g_q;
		qr_nx    = {qr_q[BIN_W-2:0], ge_r};
		qg_nx    = {qg_q[BIN_W-2:0], ge_g};
	end

	// Division datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			rem_r_q <= NUM_W'(CHROMA_MUL) * NUM_W'(red) + NUM_W'(sum1);
			rem_g_q <= NUM_W'(CHROMA_MUL) * NUM_W'(green) + NUM_W'(sum1);
			dsh_q   <= DSH_W'(den) << (BIN_W - 1);
			qr_q    <= '0;
			qg_q    <= '0;
		end else begin
			rem_r_q <= rem_r_nx;
			rem_g_q <= rem_g_nx;
			dsh_q   <= dsh_q >> 1;
			qr_q    <= qr_nx;
			qg_q    <= qg_nx;
		end
	end

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_IDLE) begin
				step_q <= STEP_W'(BIN_W - 1);
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Next state and queue writes. A pixel is only taken when the queue has
	// room, and only this side fills it, so the final push always fits.
	always_comb begin
		state_d    = state_q;
		q_push     = 1'b0;
		q_data.op  = OP_PIXEL;
		q_data.row = qr_nx;
		q_data.col = qg_nx;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (kind == KIND_PIXEL) begin
						state_d = F_DIV;
					end else if (kind == KIND_READ) begin
						q_push     = 1'b1;
						q_data.op  = OP_READ;
						q_data.row = read_red_bin;
						q_data.col = read_green_bin;
					end else if (kind == KIND_CLEAR) begin
						q_push    = 1'b1;
						q_data.op = OP_CLEAR;
					end
				end
			end
			F_DIV: begin
				if (step_q == '0) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

endmodule

>>> hdl/rgch_fifo.sv
// Short command queue between the front and back parts.
module rgch_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rgch_pkg::cmd_t push_data,
	input  logic           pop,
	output rgch_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import rgch_pkg::*;

	cmd_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/rgch_div.sv
// Bit-serial divider for the unsigned Q1.16 fraction count / total.
module rgch_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rgch_pkg::COUNT_W-1:0]  dividend,
	input  logic [rgch_pkg::COUNT_W-1:0]  divisor,
	output logic                          done,
	output logic [rgch_pkg::FRAC_W-1:0]   quotient
);
	import rgch_pkg::*;

	logic [COUNT_W:0]    rem_q;
	logic [COUNT_W-1:0]  div_q;
	logic [FRAC_W-1:0]   quo_q;
	logic [FCNT_W-1:0]   cnt_q;
	logic                done_q;
	logic                ge;
	logic [COUNT_W:0]    rem_sub;

	assign done     = done_q;
	assign quotient = quo_q;

	// One quotient bit a cycle, most significant first. The count never
	// exceeds the total, so the partial remainder stays below twice the divisor.
	always_comb begin
		ge      = rem_q >= {1'b0, div_q};
		rem_sub = ge ? rem_q - {1'b0, div_q} : rem_q;
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= {rem_sub[COUNT_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	// Step counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == FCNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= FCNT_W'(FRAC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/rgch_back.sv
// Back part: bin count store, pixel total, overflow flag and bin reads.
module rgch_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rgch_pkg::cmd_t                q_head,
	output logic                          q_pop,
	output logic                          done,
	output logic [rgch_pkg::COUNT_W-1:0]  bin_count,
	output logic [rgch_pkg::FRAC_W-1:0]   fraction,
	output logic [rgch_pkg::COUNT_W-1:0]  pixel_total,
	output logic                          overflow
);
	import rgch_pkg::*;

	back_state_t          state_q, state_d;
	logic [COUNT_W-1:0]   mem [CELLS];
	logic [COUNT_W-1:0]   rd_data_q;
	logic [CELLS-1:0]     valid_q;
	logic                 rd_valid_q;
	logic [CELL_W-1:0]    addr_q;
	logic [COUNT_W-1:0]   total_q;
	logic                 ovf_q;
	logic [COUNT_W-1:0]   count_q;

	logic [CELL_W-1:0]    head_idx;
	logic [COUNT_W-1:0]   cur_count;
	logic                 at_cap;
	logic                 div_start;
	logic                 div_done;
	logic [FRAC_W-1:0]    div_quo;

	logic                 done_q;
	logic [COUNT_W-1:0]   bin_count_q, pixel_total_q;
	logic [FRAC_W-1:0]    fraction_q;
	logic                 overflow_q;

	assign head_idx  = CELL_W'(q_head.row * BINS_PER_AXIS + q_head.col);
	assign cur_count = rd_valid_q ? rd_data_q : '0;
	assign at_cap    = total_q == COUNT_W'(MAX_PIXELS);

	assign done        = done_q;
	assign bin_count   = bin_count_q;
	assign fraction    = fraction_q;
	assign pixel_total = pixel_total_q;
	assign overflow    = overflow_q;

	// Count store: one write port, one registered read at the queue head.
	always_ff @(posedge clk) begin
		if (state_q == B_UPD) begin
			mem[addr_q] <= cur_count + 1'b1;
		end
		rd_data_q <= mem[head_idx];
	end

	// Per-entry valid bits stand in for a zeroed store after reset or clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[head_idx];
			if (state_q == B_IDLE && !q_empty && q_head.op == OP_CLEAR) begin
				valid_q <= '0;
			end else if (state_q == B_UPD) begin
				valid_q[addr_q] <= 1'b1;
			end
		end
	end

	// Control state, total and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			total_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == B_DIV) && div_done;
			if (state_q == B_IDLE && !q_empty) begin
				if (q_head.op == OP_CLEAR) begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end else if (q_head.op == OP_PIXEL && at_cap) begin
					ovf_q <= 1'b1;
				end
			end else if (state_q == B_UPD) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	// Working registers and the result registers.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			addr_q <= head_idx;
		end
		if (state_q == B_LOAD) begin
			count_q <= cur_count;
		end
		if (state_q == B_DIV && div_done) begin
			bin_count_q   <= count_q;
			fraction_q    <= (total_q == '0) ? '0 : div_quo;
			pixel_total_q <= total_q;
			overflow_q    <= ovf_q;
		end
	end

	// Next state: a pixel reads then writes back its bin unless the total is
	// at its cap; a read loads the bin and runs the fraction divider.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_head.op)
						OP_PIXEL: state_d = at_cap ? B_IDLE : B_UPD;
						OP_READ:  state_d = B_LOAD;
						OP_CLEAR: state_d = B_IDLE;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_UPD: state_d = B_IDLE;
			B_LOAD: begin
				div_start = 1'b1;
				state_d   = B_DIV;
			end
			B_DIV: begin
				if (div_done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	rgch_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cur_count),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule
